// ===== hw/rtl/asf_pkg.sv =====
`default_nettype none

package asf_pkg;

  localparam int unsigned MAX_ORDER = 4;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_FRAC = 14;

  // coefficient registers hold four 16-bit lanes
  localparam int unsigned LANES    = 4;
  localparam int unsigned LANE_W   = 16;
  localparam int unsigned COEF_W   = LANES * LANE_W;
  localparam int unsigned ORDER_W  = 3;
  localparam int unsigned CNT_W    = $clog2(MAX_ORDER + 1);

  localparam int unsigned PROD_W   = LANE_W + SAMPLE_W;
  localparam int unsigned INNOV_W  = SAMPLE_W + COEF_FRAC + 1;
  localparam int unsigned ACC_W    = ((PROD_W > INNOV_W) ? PROD_W : INNOV_W) + 4;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_AR_ORDER = 2'd0,
    REG_MA_ORDER = 2'd1,
    REG_AR_COEF  = 2'd2,
    REG_MA_COEF  = 2'd3
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asf_in_if.sv =====
`default_nettype none

interface asf_in_if;
  logic              valid;
  logic              ready;
  asf_pkg::sample_t  innovation;
  logic              new_series;

  modport source (output valid, output innovation, output new_series, input ready);
  modport sink (input valid, input innovation, input new_series, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asf_out_if.sv =====
`default_nettype none

interface asf_out_if;
  logic              valid;
  logic              ready;
  asf_pkg::sample_t  approx_sample;
  logic              saturated;

  modport source (output valid, output approx_sample, output saturated, input ready);
  modport sink (input valid, input approx_sample, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/arma_synthesis_filter.sv =====
// the accepted word passes the input register, then the result register
// throughput: one word per cycle unless the output stalls; the output feedback closes
// inside the single multiply-accumulate pass between the input register and the result register
// reset: asynchronous active low; clears orders, coefficients, warm-up count,
// sample histories and the valid flags of both registers
`default_nettype none

module arma_synthesis_filter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  asf_in_if.sink                                 in_i,
  asf_out_if.source                              out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [asf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [asf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [asf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int unsigned SW = asf_pkg::SAMPLE_W;
  localparam int unsigned AW = asf_pkg::ACC_W;
  localparam int unsigned MO = asf_pkg::MAX_ORDER;

  // configuration registers
  logic [asf_pkg::ORDER_W-1:0] ar_order_q, ma_order_q;
  logic [asf_pkg::COEF_W-1:0]  ar_coef_q, ma_coef_q;
  asf_pkg::cfg_reg_e           reg_sel;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = asf_pkg::cfg_reg_e'(paddr[asf_pkg::CFG_ADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_order_q <= '0;
      ma_order_q <= '0;
      ar_coef_q  <= '0;
      ma_coef_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        asf_pkg::REG_AR_ORDER: ar_order_q <= pwdata[asf_pkg::ORDER_W-1:0];
        asf_pkg::REG_MA_ORDER: ma_order_q <= pwdata[asf_pkg::ORDER_W-1:0];
        asf_pkg::REG_AR_COEF:  ar_coef_q  <= pwdata[asf_pkg::COEF_W-1:0];
        asf_pkg::REG_MA_COEF:  ma_coef_q  <= pwdata[asf_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      asf_pkg::REG_AR_ORDER: prdata[asf_pkg::ORDER_W-1:0] = ar_order_q;
      asf_pkg::REG_MA_ORDER: prdata[asf_pkg::ORDER_W-1:0] = ma_order_q;
      asf_pkg::REG_AR_COEF:  prdata[asf_pkg::COEF_W-1:0]  = ar_coef_q;
      asf_pkg::REG_MA_COEF:  prdata[asf_pkg::COEF_W-1:0]  = ma_coef_q;
      default: ;
    endcase
  end

  // input register
  logic             s1_valid_q;
  asf_pkg::sample_t s1_innov_q;
  logic             s1_fresh_q;
  logic             advance;
  logic             s1_fire;

  assign advance  = !out_o.valid || out_o.ready;
  assign s1_fire  = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_innov_q <= in_i.innovation;
      s1_fresh_q <= in_i.new_series;
    end
  end

  // filter state
  logic [asf_pkg::CNT_W-1:0] warm_cnt_q;
  asf_pkg::sample_t          y_hist_q [MO];
  asf_pkg::sample_t          e_hist_q [MO];

  logic [asf_pkg::ORDER_W-1:0] p_ord, q_ord, warm_ord;
  logic [asf_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic signed [asf_pkg::PROD_W-1:0] ar_prod [MO];
  logic signed [asf_pkg::PROD_W-1:0] ma_prod [MO];
  logic signed [AW-1:0]        acc, acc_rnd, y_wide;
  logic                        ovf, in_warmup;
  asf_pkg::sample_t            y_d;
  logic                        sat_d;

  always_comb begin
    p_ord = (ar_order_q > asf_pkg::ORDER_W'(MO)) ? asf_pkg::ORDER_W'(MO) : ar_order_q;
    q_ord = (ma_order_q > asf_pkg::ORDER_W'(MO)) ? asf_pkg::ORDER_W'(MO) : ma_order_q;
    warm_ord = (p_ord > q_ord) ? p_ord : q_ord;
    cnt = s1_fresh_q ? '0 : warm_cnt_q;
    in_warmup = asf_pkg::ORDER_W'(cnt) < warm_ord;
    cnt_next = (cnt < asf_pkg::CNT_W'(MO)) ? cnt + 1'b1 : cnt;
  end

  always_comb begin
    for (int m = 0; m < MO; m++) begin
      ar_prod[m] = signed'(ar_coef_q[m*asf_pkg::LANE_W +: asf_pkg::LANE_W]) * y_hist_q[m];
      ma_prod[m] = signed'(ma_coef_q[m*asf_pkg::LANE_W +: asf_pkg::LANE_W]) * e_hist_q[m];
    end
  end

  always_comb begin
    acc = AW'(s1_innov_q) <<< asf_pkg::COEF_FRAC;
    for (int m = 0; m < MO; m++) begin
      if (asf_pkg::ORDER_W'(m) < p_ord) begin
        acc = acc + AW'(ar_prod[m]);
      end
      if (asf_pkg::ORDER_W'(m) < q_ord) begin
        acc = acc + AW'(ma_prod[m]);
      end
    end
    // round half up, then floor
    acc_rnd = acc + (AW'(1) <<< (asf_pkg::COEF_FRAC - 1));
    y_wide  = acc_rnd >>> asf_pkg::COEF_FRAC;
    // out of range when the bits above the sample are not a sign extension
    ovf = !((&y_wide[AW-1:SW-1]) || !(|y_wide[AW-1:SW-1]));
    if (in_warmup) begin
      y_d   = s1_innov_q;
      sat_d = 1'b0;
    end else if (ovf) begin
      y_d   = y_wide[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      sat_d = 1'b1;
    end else begin
      y_d   = y_wide[SW-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_cnt_q <= '0;
      for (int m = 0; m < MO; m++) begin
        y_hist_q[m] <= '0;
        e_hist_q[m] <= '0;
      end
    end else if (s1_fire) begin
      warm_cnt_q  <= cnt_next;
      y_hist_q[0] <= y_d;
      e_hist_q[0] <= s1_innov_q;
      for (int m = 1; m < MO; m++) begin
        y_hist_q[m] <= y_hist_q[m-1];
        e_hist_q[m] <= e_hist_q[m-1];
      end
    end
  end

  // result register
  logic             out_valid_q;
  asf_pkg::sample_t out_sample_q;
  logic             out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_sample_q <= y_d;
      out_sat_q    <= sat_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.approx_sample = out_sample_q;
  assign out_o.saturated     = out_sat_q;

endmodule

`default_nettype wire

// ===== test/arma_synthesis_filter_tb.sv =====
module arma_synthesis_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 16;
  localparam int unsigned PHASE_WORDS   = 100;

  typedef struct packed {
    asf_pkg::sample_t innovation;
    logic             new_series;
  } innov_word_t;

  typedef struct packed {
    asf_pkg::sample_t approx_sample;
    logic             saturated;
  } arma_out_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [asf_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [asf_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [asf_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  asf_in_if  in_if ();
  asf_out_if out_if ();

  arma_synthesis_filter DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter state as the block should hold it
  logic [asf_pkg::ORDER_W-1:0] ar_ord = '0;
  logic [asf_pkg::ORDER_W-1:0] ma_ord = '0;
  logic [asf_pkg::COEF_W-1:0]  ar_coef = '0;
  logic [asf_pkg::COEF_W-1:0]  ma_coef = '0;
  int unsigned                 warm_cnt = 0;
  asf_pkg::sample_t            y_hist [asf_pkg::LANES];
  asf_pkg::sample_t            e_hist [asf_pkg::LANES];

  innov_word_t innovations_queued [$];
  arma_out_t   outputs_due [$];
  innov_word_t next_word;
  arma_out_t   want;

  int unsigned gap_odds = 0;
  int unsigned stall_odds = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cycle_count = 0;
  int unsigned words_fed = 0;
  int unsigned words_checked = 0;
  int unsigned clipped_count = 0;
  int unsigned settings_count = 0;
  int unsigned mismatch_count = 0;

  initial begin
    for (int i = 0; i < asf_pkg::LANES; i++) begin
      y_hist[i] = '0;
      e_hist[i] = '0;
    end
  end

  function automatic arma_out_t next_output(asf_pkg::sample_t e, logic fresh);
    int unsigned p, q, warm;
    int          m;
    longint      acc, y, smax, smin;
    arma_out_t   r;
    smax = (64'sd1 <<< (asf_pkg::SAMPLE_W - 1)) - 1;
    smin = -(64'sd1 <<< (asf_pkg::SAMPLE_W - 1));
    p = (ar_ord > asf_pkg::MAX_ORDER) ? asf_pkg::MAX_ORDER : ar_ord;
    q = (ma_ord > asf_pkg::MAX_ORDER) ? asf_pkg::MAX_ORDER : ma_ord;
    warm = (p > q) ? p : q;
    r.saturated = 1'b0;
    if (fresh) warm_cnt = 0;
    if (warm_cnt < warm) begin
      y = e;
    end else begin
      acc = longint'(e) <<< asf_pkg::COEF_FRAC;
      for (m = 0; m < p; m++)
        acc += longint'($signed(ar_coef[asf_pkg::LANE_W*m +: asf_pkg::LANE_W]))
               * longint'(y_hist[m]);
      for (m = 0; m < q; m++)
        acc += longint'($signed(ma_coef[asf_pkg::LANE_W*m +: asf_pkg::LANE_W]))
               * longint'(e_hist[m]);
      // add half an lsb, then floor
      y = (acc + (64'sd1 <<< (asf_pkg::COEF_FRAC - 1))) >>> asf_pkg::COEF_FRAC;
      if (y > smax) begin
        y = smax;
        r.saturated = 1'b1;
      end
      if (y < smin) begin
        y = smin;
        r.saturated = 1'b1;
      end
    end
    if (warm_cnt < asf_pkg::MAX_ORDER) warm_cnt++;
    for (m = asf_pkg::LANES - 1; m > 0; m--) begin
      y_hist[m] = y_hist[m-1];
      e_hist[m] = e_hist[m-1];
    end
    y_hist[0] = asf_pkg::sample_t'(y);
    e_hist[0] = e;
    r.approx_sample = asf_pkg::sample_t'(y);
    return r;
  endfunction

  // input side: feeds queued words, idles in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        outputs_due = {outputs_due, next_output(in_if.innovation, in_if.new_series)};
        words_fed++;
      end
      if (in_if.valid && !in_if.ready) begin
        // word held until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
        gap_left <= $urandom_range(0, 17);
        in_if.valid <= 1'b0;
      end else if (innovations_queued.size() > 0) begin
        next_word = innovations_queued.pop_front();
        in_if.valid <= 1'b1;
        in_if.innovation <= next_word.innovation;
        in_if.new_series <= next_word.new_series;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output side: stalls in bursts, checks every word taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (outputs_due.size() == 0) begin
          $error("output word with no sample pending: approx_sample %0d",
                 out_if.approx_sample);
          mismatch_count++;
        end else begin
          want = outputs_due.pop_front();
          if (out_if.approx_sample !== want.approx_sample) begin
            $error("approx_sample: expected %0d, got %0d",
                   want.approx_sample, out_if.approx_sample);
            mismatch_count++;
          end
          if (out_if.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_if.saturated);
            mismatch_count++;
          end
          words_checked++;
          if (want.saturated) clipped_count++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still due",
               cycle_count, outputs_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (innovations_queued.size() != 0 || in_if.valid || outputs_due.size() != 0);
  endtask

  task automatic write_reg(input asf_pkg::cfg_reg_e idx,
                           input logic [asf_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      asf_pkg::REG_AR_ORDER: ar_ord = value[asf_pkg::ORDER_W-1:0];
      asf_pkg::REG_MA_ORDER: ma_ord = value[asf_pkg::ORDER_W-1:0];
      asf_pkg::REG_AR_COEF:  ar_coef = value[asf_pkg::COEF_W-1:0];
      asf_pkg::REG_MA_COEF:  ma_coef = value[asf_pkg::COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [asf_pkg::ORDER_W-1:0] ar_o,
                            input logic [asf_pkg::ORDER_W-1:0] ma_o,
                            input logic [asf_pkg::COEF_W-1:0] ar_c,
                            input logic [asf_pkg::COEF_W-1:0] ma_c);
    drain();
    write_reg(asf_pkg::REG_AR_ORDER, asf_pkg::CFG_DATA_W'(ar_o));
    write_reg(asf_pkg::REG_MA_ORDER, asf_pkg::CFG_DATA_W'(ma_o));
    write_reg(asf_pkg::REG_AR_COEF, ar_c);
    write_reg(asf_pkg::REG_MA_COEF, ma_c);
    settings_count++;
    @(negedge clk_i);
  endtask

  task automatic feed(input asf_pkg::sample_t e, input logic fresh);
    innov_word_t w;
    w.innovation = e;
    w.new_series = fresh;
    innovations_queued = {innovations_queued, w};
  endtask

  function automatic logic [asf_pkg::COEF_W-1:0] pick_coefs();
    logic [asf_pkg::COEF_W-1:0] c;
    logic [asf_pkg::LANE_W-1:0] ln;
    int unsigned                style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < asf_pkg::LANES; i++) begin
      case (style)
        0: ln = asf_pkg::LANE_W'($urandom);
        3: begin
          case ($urandom_range(0, 4))
            0: ln = 16'h7FFF;
            1: ln = 16'h8000;
            2: ln = 16'h0000;
            3: ln = 16'h4000;
            default: ln = 16'hC000;
          endcase
        end
        // small taps keep the recursion stable
        default: begin
          ln = asf_pkg::LANE_W'($urandom_range(0, 2047));
          if ($urandom_range(0, 1)) ln = -ln;
        end
      endcase
      c[asf_pkg::LANE_W*i +: asf_pkg::LANE_W] = ln;
    end
    return c;
  endfunction

  initial begin
    asf_pkg::sample_t e;
    logic             fresh;
    in_if.valid = 1'b0;
    in_if.innovation = '0;
    in_if.new_series = 1'b0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // orders at reset: output follows input
    gap_odds = 4;
    stall_odds = 4;
    feed(16'sh7FFF, 1'b1);
    feed(16'sh8000, 1'b0);
    feed(16'sh0000, 1'b0);
    feed(-16'sd1, 1'b0);
    feed(16'sd1, 1'b1);

    // full orders, largest taps: warm-up then clipping both ways
    set_filter(3'd4, 3'd4, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
    feed(16'sh7FFF, 1'b1);
    repeat (4) feed(16'sh7FFF, 1'b0);
    feed(16'sh8000, 1'b1);
    repeat (4) feed(16'sh8000, 1'b0);

    // orders above the maximum act as the maximum
    set_filter(3'd7, 3'd5, 64'h8000_8000_8000_8000, 64'h4000_4000_4000_4000);
    feed(16'sd1000, 1'b1);
    feed(16'sd2000, 1'b0);
    feed(-16'sd3000, 1'b0);
    feed(16'sd4000, 1'b0);
    feed(16'sd12000, 1'b0);
    feed(-16'sd20000, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_filter(asf_pkg::ORDER_W'($urandom_range(0, 7)),
                 asf_pkg::ORDER_W'($urandom_range(0, 7)),
                 pick_coefs(), pick_coefs());
      if (ph >= RANDOM_PHASES - 3) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 3;
          default: gap_odds = 12;
        endcase
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 3;
          default: stall_odds = 12;
        endcase
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // without a restart at the phase start, the warm-up count carries over from the last phase
        fresh = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
        e = asf_pkg::sample_t'($urandom);
        if ($urandom_range(0, 15) == 0) e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        feed(e, fresh);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("checked %0d of %0d samples over %0d filter settings, %0d of them clipped",
             words_checked, words_fed, settings_count + 1, clipped_count);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
